### design/plst_pkg.sv
// ============================================================================
// plst_pkg - shared types and codes for the positional list store
// Request and response payloads, command codes and status codes.
// ============================================================================
package plst_pkg;

    // Fixed field widths of the request and response payloads
    localparam int CMD_W = 3;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    // Command codes (code 7 is unused and does nothing)
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_PRED   = 3'd4,
        CMD_SUCC   = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd_code;

    // Response status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_NONE   = 2'd3
    } t_status;

    // Command request payload
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_cmd_req;

    // Response payload
    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value_out;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] list_length;
        logic             is_empty;
    } t_rsp;

endpackage

### design/plst_if.sv
// ============================================================================
// plst_if - valid/ready channels of the positional list store
// One channel for command requests, one for responses.
// ============================================================================
interface plst_cmd_if;
    logic                 valid;
    logic                 ready;
    plst_pkg::t_cmd_req   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface plst_rsp_if;
    logic             valid;
    logic             ready;
    plst_pkg::t_rsp   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/plst_mem.sv
// ============================================================================
// plst_mem - entry memory of the positional list store
// One write port and one read port, read data registered.
// ============================================================================
module plst_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/plst_ctrl.sv
// ============================================================================
// plst_ctrl - command sequencer of the positional list store
// Walks the entry memory one entry per cycle for shifts and searches,
// keeps the length count and holds the response register.
// ============================================================================
module plst_ctrl #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    plst_cmd_if.sink                    i_cmd,
    plst_rsp_if.source                  o_rsp,
    output logic                        o_rd_en,
    output logic [$clog2(CAPACITY)-1:0] o_rd_addr,
    input  logic [ELEMENT_WIDTH-1:0]    i_rd_data,
    output logic                        o_wr_en,
    output logic [$clog2(CAPACITY)-1:0] o_wr_addr,
    output logic [ELEMENT_WIDTH-1:0]    o_wr_data
);
    import plst_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INS  = 7'b0000010,
        S_DEL  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_SUCC = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    logic [CMD_W-1:0]         r_op, n_op;
    logic [ELEMENT_WIDTH-1:0] r_val, n_val;
    logic [CW-1:0]            r_p0, n_p0;
    logic [CW-1:0]            r_k, n_k;
    logic                     r_rv, n_rv;
    logic [CW-1:0]            r_ra, n_ra;
    logic [ELEMENT_WIDTH-1:0] r_prev, n_prev;
    logic [CW-1:0]            r_count, n_count;
    t_status                  r_status, n_status;
    logic [ELEMENT_WIDTH-1:0] r_vout, n_vout;
    logic [CW-1:0]            r_fpos, n_fpos;
    logic                     r_out_valid, n_out_valid;
    t_rsp                     r_out, n_out;

    logic [LW-1:0]            pos_x;
    logic [LW-1:0]            cnt_x;
    logic                     pos_ok;
    logic                     ins_ok;
    logic [CW-1:0]            k_inc;
    logic [CW-1:0]            k_dec;
    logic [CW-1:0]            ra_inc;
    logic [CW-1:0]            ra_dec;
    logic                     hit;

    // Position checks and index arithmetic
    assign pos_x  = LW'(i_cmd.payload.position);
    assign cnt_x  = LW'(r_count);
    assign pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
    assign ins_ok = (pos_x != '0) && (pos_x <= LW'(cnt_x + LW'(1)));
    assign k_inc  = CW'(r_k + CW'(1));
    assign k_dec  = CW'(r_k - CW'(1));
    assign ra_inc = CW'(r_ra + CW'(1));
    assign ra_dec = CW'(r_ra - CW'(1));
    assign hit    = r_rv && (i_rd_data == r_val);

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_p0        = r_p0;
        n_k         = r_k;
        n_rv        = 1'b0;
        n_ra        = r_ra;
        n_prev      = r_prev;
        n_count     = r_count;
        n_status    = r_status;
        n_vout      = r_vout;
        n_fpos      = r_fpos;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_k[AW-1:0];
        o_wr_en     = 1'b0;
        o_wr_addr   = r_p0[AW-1:0];
        o_wr_data   = i_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op     = i_cmd.payload.command;
                    n_val    = ELEMENT_WIDTH'(i_cmd.payload.value);
                    n_p0     = CW'(pos_x - LW'(1));
                    n_status = ST_OK;
                    n_vout   = '0;
                    n_fpos   = '0;
                    n_k      = '0;
                    n_state  = S_DONE;
                    unique case (i_cmd.payload.command)
                        CMD_INSERT: begin
                            if (!ins_ok) begin
                                n_status = ST_BADPOS;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_k     = r_count;
                                n_state = S_INS;
                            end
                        end
                        CMD_DELETE, CMD_READ: begin
                            if (!pos_ok) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_k     = CW'(pos_x - LW'(1));
                                n_state = (i_cmd.payload.command == CMD_DELETE) ?
                                          S_DEL : S_RD;
                            end
                        end
                        CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
                            n_state = S_SCAN;
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                            // unused code: no change, status ok
                        end
                    endcase
                end
            end

            // Shift entries up from the top down, then drop the new value in
            S_INS: begin
                if (r_rv) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = ra_inc[AW-1:0];
                    o_wr_data = i_rd_data;
                end
                if (r_k > r_p0) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = k_dec[AW-1:0];
                    n_rv      = 1'b1;
                    n_ra      = k_dec;
                    n_k       = k_dec;
                end else if (!r_rv) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_p0[AW-1:0];
                    o_wr_data = r_val;
                    n_count   = CW'(r_count + CW'(1));
                    n_state   = S_DONE;
                end
            end

            // First read returns the removed entry, later ones move down by one
            S_DEL: begin
                if (r_rv) begin
                    if (r_ra == r_p0) begin
                        n_vout = i_rd_data;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = ra_dec[AW-1:0];
                        o_wr_data = i_rd_data;
                    end
                end
                if (r_k < r_count) begin
                    o_rd_en = 1'b1;
                    n_rv    = 1'b1;
                    n_ra    = r_k;
                    n_k     = k_inc;
                end else if (!r_rv) begin
                    n_count = CW'(r_count - CW'(1));
                    n_state = S_DONE;
                end
            end

            // Single entry read
            S_RD: begin
                if (r_rv) begin
                    n_vout  = i_rd_data;
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_rv    = 1'b1;
                    n_ra    = r_k;
                end
            end

            // Search from the first entry; reads run one ahead of the compare
            S_SCAN: begin
                if (r_k < r_count) begin
                    o_rd_en = 1'b1;
                    n_rv    = 1'b1;
                    n_ra    = r_k;
                    n_k     = k_inc;
                end
                if (hit) begin
                    n_state = S_DONE;
                    if (r_op == CMD_LOCATE) begin
                        n_fpos = ra_inc;
                    end else if (r_op == CMD_PRED) begin
                        if (r_ra == '0) begin
                            n_status = ST_NONE;
                        end else begin
                            n_vout = r_prev;
                        end
                    end else if (r_k < r_count) begin
                        // neighbour read already issued this cycle
                        n_state = S_SUCC;
                    end else begin
                        n_status = ST_NONE;
                    end
                end else begin
                    if (r_rv) begin
                        n_prev = i_rd_data;
                    end
                    if (!r_rv && (r_k >= r_count)) begin
                        n_status = ST_NONE;
                        n_state  = S_DONE;
                    end
                end
            end

            // Successor data arrives
            S_SUCC: begin
                n_vout  = i_rd_data;
                n_state = S_DONE;
            end

            // Load the response register once it is free
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = r_status;
                    n_out.value_out      = VAL_W'(r_vout);
                    n_out.found_position = POS_W'(r_fpos);
                    n_out.list_length    = POS_W'(r_count);
                    n_out.is_empty       = (r_count == '0);
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rv        <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rv        <= n_rv;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_val    <= n_val;
        r_p0     <= n_p0;
        r_k      <= n_k;
        r_ra     <= n_ra;
        r_prev   <= n_prev;
        r_status <= n_status;
        r_vout   <= n_vout;
        r_fpos   <= n_fpos;
        r_out    <= n_out;
    end

endmodule

### design/positional_list_store_top.sv
// ============================================================================
// positional_list_store_top - ordered list of up to CAPACITY elements
// Insert, delete, read, locate, predecessor, successor and clear on a list
// kept in one entry memory.
// ============================================================================
// One command request is taken at a time and gives exactly one response.
// Insert and delete at position p walk the entries from p to the end of the
// list; locate, predecessor and successor walk from the first entry and stop
// early when the value is found. The single read port of the entry memory
// steps through one entry per cycle, with read data registered. No clearing
// pass is needed after reset: only entries below the length count are ever
// read. A new request is taken while the previous response still waits in
// the output register.
module positional_list_store_top #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plst_cmd_if.sink    i_cmd,
    plst_rsp_if.source  o_rsp
);
    import plst_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic [ELEMENT_WIDTH-1:0] rd_data;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;

    // Command sequencer
    plst_ctrl #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_rsp     (o_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // Entry memory
    plst_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEMENT_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

### dv/plst_list_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// plst_list_checker - response checker for the positional list store
// Watches the request and response channels, keeps its own copy of the list,
// works out the response of every accepted request and compares each
// accepted response, field by field, with the oldest outstanding one.
// ============================================================================
module plst_list_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    plst_cmd_if   i_cmd,
    plst_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_outstanding
);
    import plst_pkg::*;

    localparam int LIST_CAPACITY = 64;

    // Shadow of the list contents and its occupied length
    logic [VAL_W-1:0] list_mem [LIST_CAPACITY];
    int               list_len;

    // Responses owed by the block, oldest first
    t_rsp             expected_rsp_q[$];

    // First 0-based index holding the value, or the length when absent
    function automatic int first_hit(input logic [VAL_W-1:0] v);
        int k;
        for (k = 0; k < list_len; k++) begin
            if (list_mem[k] == v)
                return k;
        end
        return list_len;
    endfunction

    // Applies one request to the shadow list and returns its response
    function automatic t_rsp apply_list_command(input t_cmd_req req);
        t_rsp rsp;
        int   pos;
        int   hit;
        int   k;
        rsp        = '0;
        rsp.status = ST_OK;
        pos        = int'(req.position);
        case (req.command)
            CMD_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    rsp.status = ST_BADPOS;
                end else if (list_len >= LIST_CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (k = list_len; k >= pos; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos-1] = req.value;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    rsp.value_out = list_mem[pos-1];
                    for (k = pos; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (pos < 1 || pos > list_len)
                    rsp.status = ST_BADPOS;
                else
                    rsp.value_out = list_mem[pos-1];
            end
            CMD_LOCATE: begin
                hit = first_hit(req.value);
                if (hit < list_len)
                    rsp.found_position = POS_W'(hit + 1);
                else
                    rsp.status = ST_NONE;
            end
            CMD_PRED: begin
                hit = first_hit(req.value);
                if (hit < list_len && hit > 0)
                    rsp.value_out = list_mem[hit-1];
                else
                    rsp.status = ST_NONE;
            end
            CMD_SUCC: begin
                hit = first_hit(req.value);
                if (hit + 1 < list_len)
                    rsp.value_out = list_mem[hit+1];
                else
                    rsp.status = ST_NONE;
            end
            CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
                // unused code: no change, status ok
            end
        endcase
        rsp.list_length = POS_W'(list_len);
        rsp.is_empty    = (list_len == 0);
        return rsp;
    endfunction

    // One field compare; reports time, expected and actual value
    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, exp_v, act_v);
        end
    endtask

    // Channel monitor: predict on request, compare on response
    always @(posedge i_clk) begin : watch
        t_rsp exp_rsp;
        t_rsp act_rsp;
        if (i_rst_n !== 1'b1) begin
            list_len     = 0;
            o_fail_count = 0;
            expected_rsp_q.delete();
        end else begin
            if (i_cmd.valid === 1'b1 && i_cmd.ready === 1'b1)
                expected_rsp_q.push_back(apply_list_command(i_cmd.payload));
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                act_rsp = i_rsp.payload;
                if (expected_rsp_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: response mismatch, expected none, got 0x%0h",
                             $time, act_rsp);
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    check_field("status", 32'(exp_rsp.status), 32'(act_rsp.status));
                    check_field("value_out", exp_rsp.value_out, act_rsp.value_out);
                    check_field("found_position", 32'(exp_rsp.found_position),
                                32'(act_rsp.found_position));
                    check_field("list_length", 32'(exp_rsp.list_length),
                                32'(act_rsp.list_length));
                    check_field("is_empty", 32'(exp_rsp.is_empty),
                                32'(act_rsp.is_empty));
                end
            end
        end
        o_outstanding <= expected_rsp_q.size();
    end

endmodule

### dv/tb_positional_list_store_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_positional_list_store_top - testbench of the positional list store
// Drives command requests with random gaps, takes responses with random
// stalls and leaves prediction and checking to the list checker. A directed
// pass covers the edge cases, then random traffic grows, fills and drains
// the list.
// ============================================================================
module tb_positional_list_store_top;
    import plst_pkg::*;

    localparam int             LIST_CAPACITY = 64;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 3'd7;
    localparam int             RANDOM_ITEMS  = 380;
    localparam int             LONG_HOLD     = 400;
    localparam int             HOLD_AT_RSP   = 150;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_rsp;
    int   list_fill;      // occupied length as seen from the request side
    bit   no_idle;        // both sides run without gaps while set

    plst_cmd_if cmd_ch ();
    plst_rsp_if rsp_ch ();

    positional_list_store_top #(
        .CAPACITY      (LIST_CAPACITY),
        .ELEMENT_WIDTH (VAL_W)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    plst_list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .i_rsp         (rsp_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (pending_rsp)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("tb_positional_list_store_top: FAIL");
        $finish;
    end

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request and returns at the edge where it is accepted
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        t_cmd_req req;
        int       gap;
        int       p;
        req.command  = cmd;
        req.position = pos;
        req.value    = val;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.payload <= req;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        // track the length so that positions can be aimed
        p = int'(pos);
        case (cmd)
            CMD_INSERT: if (p >= 1 && p <= list_fill + 1 && list_fill < LIST_CAPACITY)
                            list_fill++;
            CMD_DELETE: if (p >= 1 && p <= list_fill)
                            list_fill--;
            CMD_CLEAR:  list_fill = 0;
            default: ;
        endcase
    endtask

    // Stop offering and wait for every outstanding response
    task automatic drain_responses();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_rsp == 0);
    endtask

    // Mostly small values so that searches hit and duplicates occur
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return VAL_W'($urandom_range(0, 15));
        if (r < 60)
            return '0;
        if (r < 65)
            return '1;
        return $urandom;
    endfunction

    // Random request, biased towards growing or shrinking the list
    task automatic send_random(input bit grow);
        logic [CMD_W-1:0] cmd;
        int               r;
        int               upper;
        logic [POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 50)      cmd = CMD_INSERT;
            else if (r < 62) cmd = CMD_DELETE;
            else if (r < 70) cmd = CMD_READ;
            else if (r < 78) cmd = CMD_LOCATE;
            else if (r < 86) cmd = CMD_PRED;
            else if (r < 96) cmd = CMD_SUCC;
            else if (r < 98) cmd = CMD_CLEAR;
            else             cmd = CMD_UNUSED;
        end else begin
            if (r < 15)      cmd = CMD_INSERT;
            else if (r < 55) cmd = CMD_DELETE;
            else if (r < 65) cmd = CMD_READ;
            else if (r < 75) cmd = CMD_LOCATE;
            else if (r < 85) cmd = CMD_PRED;
            else if (r < 96) cmd = CMD_SUCC;
            else if (r < 98) cmd = CMD_CLEAR;
            else             cmd = CMD_UNUSED;
        end
        upper = (cmd == CMD_INSERT) ? list_fill + 1 : list_fill;
        r = $urandom_range(0, 99);
        if (r < 85 && upper >= 1)
            pos = POS_W'($urandom_range(1, upper));
        else if (r < 93)
            pos = POS_W'(upper + 1);
        else if (r < 96)
            pos = '0;
        else
            pos = POS_W'($urandom_range(0, 127));
        send_request(cmd, pos, pick_value());
    endtask

    // Inserts until the list is full, then pokes at the full list
    task automatic fill_to_capacity();
        while (list_fill < LIST_CAPACITY)
            send_request(CMD_INSERT, POS_W'($urandom_range(1, list_fill + 1)),
                         pick_value());
        send_request(CMD_INSERT, POS_W'(LIST_CAPACITY + 1), pick_value());
        send_request(CMD_INSERT, 7'd1, pick_value());
        send_request(CMD_INSERT, POS_W'(LIST_CAPACITY + 2), pick_value());
        send_request(CMD_READ, POS_W'(LIST_CAPACITY), '0);
        send_request(CMD_SUCC, '0, pick_value());
        send_request(CMD_DELETE, POS_W'(LIST_CAPACITY), '0);
    endtask

    // Response side: random stalls, one long hold-off to back the block up
    initial begin
        int stall;
        int taken;
        rsp_ch.ready <= 1'b0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = (taken == HOLD_AT_RSP) ? LONG_HOLD : pick_gap();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
            taken++;
        end
    end

    // Request side and verdict
    initial begin
        int n;
        bit grow;
        list_fill = 0;
        no_idle   = 1'b0;
        grow      = 1'b1;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.payload <= '0;
        i_rst_n        <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: illegal positions and failed searches
        send_request(CMD_READ,   7'd0, '0);
        send_request(CMD_DELETE, 7'd1, '0);
        send_request(CMD_LOCATE, 7'd0, '0);
        send_request(CMD_PRED,   7'd0, '0);
        send_request(CMD_SUCC,   7'd0, '0);
        send_request(CMD_INSERT, 7'd0, 32'd5);
        send_request(CMD_INSERT, 7'd2, 32'd5);
        // Build A5A55A5A, 0, 0, FFFFFFFF
        send_request(CMD_INSERT, 7'd1, 32'h0000_0000);
        send_request(CMD_INSERT, 7'd2, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 7'd1, 32'hA5A5_5A5A);
        send_request(CMD_INSERT, 7'd3, 32'h0000_0000);
        send_request(CMD_READ,   7'd4, '0);
        send_request(CMD_READ,   7'd5, '0);
        // Searches: first occurrence, absent value, head and tail neighbours
        send_request(CMD_LOCATE, 7'd0, 32'h0000_0000);
        send_request(CMD_LOCATE, 7'd0, 32'd7);
        send_request(CMD_PRED,   7'd0, 32'hA5A5_5A5A);
        send_request(CMD_PRED,   7'd0, 32'h0000_0000);
        send_request(CMD_SUCC,   7'd0, 32'hFFFF_FFFF);
        send_request(CMD_SUCC,   7'd0, 32'h0000_0000);
        // Delete out of range and in the middle, unused code, clear
        send_request(CMD_DELETE, 7'd127, '0);
        send_request(CMD_DELETE, 7'd2, '0);
        send_request(CMD_UNUSED, 7'h55, 32'h5A5A_A5A5);
        send_request(CMD_CLEAR,  7'h2A, '1);
        send_request(CMD_READ,   7'd1, '0);

        // Random traffic in episodes that grow or drain the list
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                grow = $urandom_range(0, 1);
            if (n == 60 || n == 330)
                fill_to_capacity();
            if (n == 200)
                drain_responses();
            no_idle = (n >= 260 && n < 320);
            send_random(grow);
        end

        drain_responses();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_positional_list_store_top: PASS");
        else
            $display("tb_positional_list_store_top: FAIL");
        $finish;
    end

endmodule
